// ===== hw/rtl/etc1_pkg.sv =====
`timescale 1ns / 1ps

package etc1_pkg;

   localparam int unsigned PixelCount = 16;
   localparam int unsigned IndexWidth = $clog2(PixelCount);
   localparam logic [IndexWidth-1:0] LastIndex = IndexWidth'(PixelCount - 1);

   typedef struct packed {
      logic [31:0] color_word;
      logic [31:0] selector_word;
   } etc1_req_type;

   typedef struct packed {
      logic [1:0] pixel_x;
      logic [1:0] pixel_y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_pixel;
   } etc1_rsp_type;

   typedef logic [7:0] etc1_chan_type;
   typedef logic signed [8:0] etc1_mod_type;
   typedef logic signed [9:0] etc1_sum_type;

   function automatic etc1_mod_type mod_value(input logic [2:0] tab, input logic [1:0] sel);
      logic [7:0] mag;
      begin
         mag = 8'd0;
         case (tab)
            3'd0: mag = sel[0] ? 8'd8   : 8'd2;
            3'd1: mag = sel[0] ? 8'd17  : 8'd5;
            3'd2: mag = sel[0] ? 8'd29  : 8'd9;
            3'd3: mag = sel[0] ? 8'd42  : 8'd13;
            3'd4: mag = sel[0] ? 8'd60  : 8'd18;
            3'd5: mag = sel[0] ? 8'd80  : 8'd24;
            3'd6: mag = sel[0] ? 8'd106 : 8'd33;
            3'd7: mag = sel[0] ? 8'd183 : 8'd47;
            default: mag = 8'd0;
         endcase
         mod_value = sel[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   endfunction

   function automatic etc1_chan_type rep5(input logic [4:0] v);
      rep5 = {v, v[4:2]};
   endfunction

   function automatic etc1_chan_type sat8(input etc1_sum_type v);
      if (v[9]) begin
         sat8 = 8'd0;
      end else if (v[8]) begin
         sat8 = 8'd255;
      end else begin
         sat8 = v[7:0];
      end
   endfunction

endpackage

// ===== hw/rtl/etc1_block_decoder.sv =====
`timescale 1ns / 1ps
// An accepted block is registered; each pixel passes select, modifier add and output stages.
// Pixels leave one per cycle unless rsp_ready stalls, sixteen per block, set by the pixel counter.
// A new block is taken in the cycle its sixteenth pixel issues, so blocks stream back to back.
// Pipeline: block decode register, pixel select, modifier add, saturate/output register.
// Reset: synchronous, active high; clears all valid bits and the pixel counter.
module etc1_block_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  etc1_pkg::etc1_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output etc1_pkg::etc1_rsp_type rsp_data
);
   import etc1_pkg::*;

   logic                  blk_valid_ff;
   etc1_chan_type         base_ff [2][3];
   etc1_chan_type         base_in [2][3];
   logic [2:0]            tab_ff [2];
   logic                  flip_ff;
   logic [31:0]           sel_ff;
   logic [IndexWidth-1:0] cnt_ff;

   logic                  v1_ff;
   logic [IndexWidth-1:0] idx1_ff;
   etc1_chan_type         base1_ff [3];
   logic [2:0]            tab1_ff;
   logic [1:0]            sel1_ff;

   logic                  v2_ff;
   logic [IndexWidth-1:0] idx2_ff;
   etc1_sum_type          sum2_ff [3];
   etc1_sum_type          sum2_in [3];
   etc1_mod_type          mod2;

   logic                  v3_ff;
   etc1_rsp_type          rsp_ff;

   logic                  ready1;
   logic                  ready2;
   logic                  ready3;
   logic                  issue;
   logic                  half;
   logic [IndexWidth-1:0] cnt_in;

   assign ready3    = !v3_ff || rsp_ready;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign issue     = blk_valid_ff && ready1;
   assign req_ready = !blk_valid_ff || (issue && cnt_ff == LastIndex);
   assign cnt_in    = cnt_ff + IndexWidth'(1);
   assign half      = flip_ff ? cnt_ff[1] : cnt_ff[3];

   always_comb begin
      logic [7:0] byte_c;
      logic [4:0] b5;
      logic [4:0] d5;
      for (int c = 0; c < 3; c++) begin
         byte_c = req_data.color_word[31 - 8*c -: 8];
         b5     = byte_c[7:3];
         d5     = {{2{byte_c[2]}}, byte_c[2:0]};
         if (req_data.color_word[1]) begin
            base_in[0][c] = rep5(b5);
            base_in[1][c] = rep5(b5 + d5);
         end else begin
            base_in[0][c] = {byte_c[7:4], byte_c[7:4]};
            base_in[1][c] = {byte_c[3:0], byte_c[3:0]};
         end
      end
   end

   assign mod2 = mod_value(tab1_ff, sel1_ff);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum2_in[c] = $signed({2'b00, base1_ff[c]}) + etc1_sum_type'(mod2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (req_valid && req_ready) begin
            blk_valid_ff <= 1'b1;
         end else if (issue && cnt_ff == LastIndex) begin
            blk_valid_ff <= 1'b0;
         end
         if (issue) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         base_ff   <= base_in;
         tab_ff[0] <= req_data.color_word[7:5];
         tab_ff[1] <= req_data.color_word[4:2];
         flip_ff   <= req_data.color_word[0];
         sel_ff    <= req_data.selector_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= issue;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && issue) begin
         idx1_ff  <= cnt_ff;
         base1_ff <= base_ff[half];
         tab1_ff  <= tab_ff[half];
         sel1_ff  <= {sel_ff[{1'b1, cnt_ff}], sel_ff[{1'b0, cnt_ff}]};
      end
      if (ready2 && v1_ff) begin
         idx2_ff <= idx1_ff;
         sum2_ff <= sum2_in;
      end
      if (ready3 && v2_ff) begin
         rsp_ff.pixel_x    <= idx2_ff[3:2];
         rsp_ff.pixel_y    <= idx2_ff[1:0];
         rsp_ff.red        <= sat8(sum2_ff[0]);
         rsp_ff.green      <= sat8(sum2_ff[1]);
         rsp_ff.blue       <= sat8(sum2_ff[2]);
         rsp_ff.last_pixel <= (idx2_ff == LastIndex);
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

   a_idle_counter_zero: assert property (@(posedge clock) disable iff (reset)
      !blk_valid_ff |-> cnt_ff == '0)
      else $error("pixel counter nonzero with no block held");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_pixel |-> rsp_data.pixel_x == 2'd3 && rsp_data.pixel_y == 2'd3)
      else $error("last pixel flag off the final corner");

   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !ready2 |=> v1_ff && $stable(idx1_ff) && $stable(sel1_ff))
      else $error("stalled pixel stage lost its word");

   a_issue_order: assert property (@(posedge clock) disable iff (reset)
      issue |=> v1_ff && idx1_ff == $past(cnt_ff))
      else $error("issued pixel index not captured");

endmodule
